>>> rtl/tilt_kalman_filter_two_axis_core_macros.svh
// Assertion macros shared by the tilt Kalman filter RTL.
// Each expects clk_i and rst_ni to be visible where it is used.
`ifndef TILT_KALMAN_FILTER_TWO_AXIS_CORE_MACROS_SVH
`define TILT_KALMAN_FILTER_TWO_AXIS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tkf_pkg.sv
// Package for the two-axis tilt Kalman filter: types, constants and helpers.
// Used by the lane and the top level; depends on nothing.
package tkf_pkg;

  localparam int unsigned AxisCountDef = 2;
  localparam int unsigned DataW        = 32;
  localparam int unsigned DtW          = 24;
  localparam int unsigned NoiseW       = 28;
  localparam int unsigned CfgDataW     = 28;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [DtW-1:0]    DtReset = 24'd335544;
  localparam logic [NoiseW-1:0] QaReset = 28'd2684355;
  localparam logic [NoiseW-1:0] QbReset = 28'd80530;
  localparam logic [NoiseW-1:0] MnReset = 28'd2684355;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD_DT = 2'd0,
    REG_NOISE_ANG = 2'd1,
    REG_NOISE_BIAS = 2'd2,
    REG_MEAS_NOISE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DtW-1:0]    dt;
    logic [NoiseW-1:0] qa;
    logic [NoiseW-1:0] qb;
    logic [NoiseW-1:0] mn;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic clip;
  } lane_stat_t;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_MUL,
    LS_WB,
    LS_DIV,
    LS_DONE
  } lane_st_e;

  typedef enum logic [3:0] {
    OP_ANG,
    OP_P00,
    OP_P01,
    OP_P11,
    OP_K0,
    OP_K1,
    OP_UANG,
    OP_UBIAS,
    OP_U00,
    OP_U01,
    OP_U10,
    OP_U11
  } op_e;

  // Saturate to the signed 32-bit range; the top bit of the result flags a clip.
  function automatic logic [32:0] sat32(input logic signed [67:0] v);
    logic [32:0] r;
    if (v > 68'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -68'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic signed [67:0] ext32(input logic [31:0] x);
    return $signed({{36{x[31]}}, x});
  endfunction

endpackage

>>> rtl/tkf_in_if.sv
// Input channel of the tilt Kalman filter: one word of sensor samples.
// Depends on nothing.
interface tkf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] acc_angle_x;
  logic [31:0] gyro_rate_x;
  logic [31:0] acc_angle_y;
  logic [31:0] gyro_rate_y;

  modport source (output valid, acc_angle_x, gyro_rate_x, acc_angle_y, gyro_rate_y,
                  input ready);
  modport sink (input valid, acc_angle_x, gyro_rate_x, acc_angle_y, gyro_rate_y,
                output ready);
endinterface

>>> rtl/tkf_out_if.sv
// Output channel of the tilt Kalman filter: one word of fused angles.
// Depends on nothing.
interface tkf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fused_angle_x;
  logic [31:0] fused_angle_y;
  logic        saturated;

  modport source (output valid, fused_angle_x, fused_angle_y, saturated, input ready);
  modport sink (input valid, fused_angle_x, fused_angle_y, saturated, output ready);
endinterface

>>> rtl/tilt_kalman_filter_two_axis_core.sv
// Two-axis tilt Kalman filter: one lane per axis and a merging output stage.
// Depends on tkf_pkg, tkf_in_if, tkf_out_if and tkf_lane.
//
// Usage: each word on in_i carries an accelerometer angle and a gyro rate for
// X and Y. All axis lanes start together on an accepted word and each runs
// predict, gain and update on its own angle, bias and covariance. When every
// lane has finished, the merging stage loads one word onto out_o with both
// fused angles and a flag that is set when any value was clipped.
// From acceptance to out_o.valid, each lane runs the sequenced multiply and
// write-back steps through its single multiplier and, when S is positive,
// the two bit-serial divisions for the gains. One word is in work at a
// time; a new word is taken only once every lane is idle again.
// A finished result waits in the output register; the next word may be taken
// meanwhile, and its lanes hold their results until that register is free.
// Reset clears all filter state to zero and loads the default registers.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
module tilt_kalman_filter_two_axis_core #(
  parameter int unsigned AXIS_COUNT = tkf_pkg::AxisCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tkf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tkf_pkg::CfgDataW-1:0]  cfg_data_i,
  tkf_in_if.sink                        in_i,
  tkf_out_if.source                     out_o
);
  import tkf_pkg::*;

  cfg_t cfg_q;
  lane_stat_t stat [AXIS_COUNT];
  logic [31:0] angle [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] idle_v, done_v, clip_v;
  logic start, load;
  logic out_valid_q, out_valid_d;
  logic [31:0] fx_q, fy_q;
  logic sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dt <= DtReset;
      cfg_q.qa <= QaReset;
      cfg_q.qb <= QbReset;
      cfg_q.mn <= MnReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PERIOD_DT:  cfg_q.dt <= cfg_data_i[DtW-1:0];
        REG_NOISE_ANG:  cfg_q.qa <= cfg_data_i[NoiseW-1:0];
        REG_NOISE_BIAS: cfg_q.qb <= cfg_data_i[NoiseW-1:0];
        REG_MEAS_NOISE: cfg_q.mn <= cfg_data_i[NoiseW-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign start      = in_i.valid && in_i.ready;
  assign in_i.ready = &idle_v;

  for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_lane
    logic [31:0] acc, rate;
    if (a == 0) begin : g_x
      assign acc  = in_i.acc_angle_x;
      assign rate = in_i.gyro_rate_x;
    end else if (a == 1) begin : g_y
      assign acc  = in_i.acc_angle_y;
      assign rate = in_i.gyro_rate_y;
    end else begin : g_zero
      assign acc  = '0;
      assign rate = '0;
    end

    tkf_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start),
      .ack_i   (load),
      .acc_i   (acc),
      .rate_i  (rate),
      .cfg_i   (cfg_q),
      .stat_o  (stat[a]),
      .angle_o (angle[a])
    );

    assign idle_v[a] = stat[a].idle;
    assign done_v[a] = stat[a].done;
    assign clip_v[a] = stat[a].clip;
  end

  // Merge once every lane is done and the output register is free.
  assign load        = (&done_v) && (!out_valid_q || out_o.ready);
  assign out_valid_d = load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fx_q  <= angle[0];
      fy_q  <= (AXIS_COUNT > 1) ? angle[(AXIS_COUNT > 1) ? 1 : 0] : '0;
      sat_q <= |clip_v;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fused_angle_x = fx_q;
  assign out_o.fused_angle_y = fy_q;
  assign out_o.saturated     = sat_q;

endmodule

>>> rtl/tkf_lane.sv
// One axis of the Kalman filter: state, a shared multiplier and a bit-serial divider.
// Depends on tkf_pkg and the assertion macro header.
module tkf_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               ack_i,
  input  logic [31:0]        acc_i,
  input  logic [31:0]        rate_i,
  input  tkf_pkg::cfg_t      cfg_i,
  output tkf_pkg::lane_stat_t stat_o,
  output logic [31:0]        angle_o
);
  import tkf_pkg::*;

  localparam int unsigned NumW = 60;
  localparam logic signed [65:0] Half24 = 66'sd1 <<< 23;
  localparam logic signed [65:0] Half28 = 66'sd1 <<< 27;

  lane_st_e st_q, st_d;
  op_e      op_q, op_d;

  logic [31:0] ang_q, ang_d, bias_q, bias_d;
  logic [31:0] c00_q, c00_d, c01_q, c01_d, c10_q, c10_d, c11_q, c11_d;
  logic [31:0] wang_q, wang_d, w00_q, w00_d, w01_q, w01_d, w10_q, w10_d, w11_q, w11_d;
  logic [31:0] y_q, y_d, k0_q, k0_d, k1_q, k1_d, s_q, s_d;
  logic [31:0] acc_q, acc_d, rate_q, rate_d, rem_q, rem_d;
  logic [NumW-1:0] num_q, num_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, clip_q, clip_d;
  logic signed [65:0] prod_q, prod_d;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] t24, t28;
  logic signed [67:0] r24, r28, s_full;
  logic [32:0] sv0, sv1, yv;
  logic [32:0] rem_sh, rem_n;
  logic        ge;
  logic [NumW-1:0] q_fin;
  logic signed [67:0] q_sgn;
  logic [31:0] dmag;
  logic        dneg;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = $signed({8'd0, cfg_i.dt});
    case (op_q)
      OP_ANG:   mul_a = 34'($signed(rate_q)) - 34'($signed(bias_q));
      OP_P00:   mul_a = $signed({6'd0, cfg_i.qa}) -
                        (34'($signed(c01_q)) + 34'($signed(c10_q)));
      OP_P01:   mul_a = -34'($signed(c11_q));
      OP_P11:   mul_a = $signed({6'd0, cfg_i.qb});
      OP_UANG:  begin mul_a = 34'($signed(k0_q)); mul_b = $signed(y_q);   end
      OP_UBIAS: begin mul_a = 34'($signed(k1_q)); mul_b = $signed(y_q);   end
      OP_U00:   begin mul_a = 34'($signed(k0_q)); mul_b = $signed(w00_q); end
      OP_U01:   begin mul_a = 34'($signed(k0_q)); mul_b = $signed(w01_q); end
      OP_U10:   begin mul_a = 34'($signed(k1_q)); mul_b = $signed(w00_q); end
      OP_U11:   begin mul_a = 34'($signed(k1_q)); mul_b = $signed(w01_q); end
      default:  mul_a = '0;
    endcase
    prod_d = 66'(mul_a) * 66'(mul_b);
  end

  always_comb begin
    t24 = (prod_q + Half24) >>> 24;
    t28 = (prod_q + Half28) >>> 28;
    r24 = 68'(t24);
    r28 = 68'(t28);
    yv  = sat32(ext32(acc_q) - ext32(wang_q));
    s_full = ext32(w00_q) + $signed({40'd0, cfg_i.mn});
    rem_sh = {rem_q, num_q[NumW-1]};
    ge     = rem_sh >= {1'b0, s_q};
    rem_n  = ge ? (rem_sh - {1'b0, s_q}) : rem_sh;
    q_fin  = {num_q[NumW-2:0], ge};
    q_sgn  = neg_q ? -$signed({8'd0, q_fin}) : $signed({8'd0, q_fin});
  end

  always_comb begin
    st_d = st_q;   op_d = op_q;
    ang_d = ang_q; bias_d = bias_q;
    c00_d = c00_q; c01_d = c01_q; c10_d = c10_q; c11_d = c11_q;
    wang_d = wang_q; w00_d = w00_q; w01_d = w01_q; w10_d = w10_q; w11_d = w11_q;
    y_d = y_q; k0_d = k0_q; k1_d = k1_q; s_d = s_q;
    acc_d = acc_q; rate_d = rate_q; rem_d = rem_q; num_d = num_q;
    cnt_d = cnt_q; neg_d = neg_q; clip_d = clip_q;
    sv0 = '0; sv1 = '0;
    dmag = '0; dneg = 1'b0;

    case (st_q)
      LS_IDLE: begin
        if (start_i) begin
          acc_d  = acc_i;
          rate_d = rate_i;
          clip_d = 1'b0;
          op_d   = OP_ANG;
          st_d   = LS_MUL;
        end
      end
      LS_MUL: st_d = LS_WB;
      LS_WB: begin
        st_d = LS_MUL;
        op_d = op_e'(op_q + 4'd1);
        case (op_q)
          OP_ANG: begin sv0 = sat32(ext32(ang_q) + r24); wang_d = sv0[31:0]; end
          OP_P00: begin sv0 = sat32(ext32(c00_q) + r24); w00_d = sv0[31:0]; end
          OP_P01: begin
            sv0 = sat32(ext32(c01_q) + r24); w01_d = sv0[31:0];
            sv1 = sat32(ext32(c10_q) + r24); w10_d = sv1[31:0];
          end
          OP_P11: begin
            sv0 = sat32(ext32(c11_q) + r24); w11_d = sv0[31:0];
            sv1 = yv; y_d = yv[31:0];
            if (s_full > 68'sd0) begin
              // The gain divides by S, one quotient bit per cycle.
              s_d   = s_full[31:0];
              dneg  = w00_q[31];
              dmag  = dneg ? (32'd0 - w00_q) : w00_q;
              neg_d = dneg;
              num_d = {dmag, 28'd0};
              rem_d = '0;
              cnt_d = '0;
              op_d  = OP_K0;
              st_d  = LS_DIV;
            end else begin
              k0_d = '0;
              k1_d = '0;
              op_d = OP_UANG;
            end
          end
          OP_UANG:  begin sv0 = sat32(ext32(wang_q) + r28); ang_d  = sv0[31:0]; end
          OP_UBIAS: begin sv0 = sat32(ext32(bias_q) + r28); bias_d = sv0[31:0]; end
          OP_U00:   begin sv0 = sat32(ext32(w00_q) - r28); c00_d = sv0[31:0]; end
          OP_U01:   begin sv0 = sat32(ext32(w01_q) - r28); c01_d = sv0[31:0]; end
          OP_U10:   begin sv0 = sat32(ext32(w10_q) - r28); c10_d = sv0[31:0]; end
          OP_U11: begin
            sv0 = sat32(ext32(w11_q) - r28); c11_d = sv0[31:0];
            st_d = LS_DONE;
          end
          default: st_d = LS_DONE;
        endcase
        clip_d = clip_q | sv0[32] | sv1[32];
      end
      LS_DIV: begin
        rem_d = rem_n[31:0];
        num_d = q_fin;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NumW - 1)) begin
          sv0    = sat32(q_sgn);
          clip_d = clip_q | sv0[32];
          if (op_q == OP_K0) begin
            k0_d  = sv0[31:0];
            dneg  = w10_q[31];
            dmag  = dneg ? (32'd0 - w10_q) : w10_q;
            neg_d = dneg;
            num_d = {dmag, 28'd0};
            rem_d = '0;
            cnt_d = '0;
            op_d  = OP_K1;
          end else begin
            k1_d = sv0[31:0];
            op_d = OP_UANG;
            st_d = LS_MUL;
          end
        end
      end
      LS_DONE: begin
        if (ack_i) begin
          st_d = LS_IDLE;
        end
      end
      default: st_d = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LS_IDLE;
      op_q   <= OP_ANG;
      ang_q  <= '0;
      bias_q <= '0;
      c00_q  <= '0;
      c01_q  <= '0;
      c10_q  <= '0;
      c11_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      op_q   <= op_d;
      ang_q  <= ang_d;
      bias_q <= bias_d;
      c00_q  <= c00_d;
      c01_q  <= c01_d;
      c10_q  <= c10_d;
      c11_q  <= c11_d;
      clip_q <= clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wang_q <= wang_d;
    w00_q  <= w00_d;
    w01_q  <= w01_d;
    w10_q  <= w10_d;
    w11_q  <= w11_d;
    y_q    <= y_d;
    k0_q   <= k0_d;
    k1_q   <= k1_d;
    s_q    <= s_d;
    acc_q  <= acc_d;
    rate_q <= rate_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
  end

  assign stat_o.idle = (st_q == LS_IDLE);
  assign stat_o.done = (st_q == LS_DONE);
  assign stat_o.clip = clip_q;
  assign angle_o     = ang_q;

  `include "tilt_kalman_filter_two_axis_core_macros.svh"

  `TKF_ASSERT_NOW(a_div_nonzero, st_q == LS_DIV, s_q != '0, "divide by a zero divisor")
  `TKF_ASSERT_NOW(a_start_idle, start_i, st_q == LS_IDLE, "lane started while busy")
  `TKF_ASSERT_NEXT(a_ack_frees, ack_i && st_q == LS_DONE, st_q == LS_IDLE, "lane held after ack")

endmodule
